@@ sv/fcgi_rd_pkg.sv @@
// ----------------------------------------------------------------------------
// FastCGI record deframer package
// Shared constants, codes and types for the record deframer and its header
// decoder.
// ----------------------------------------------------------------------------
package fcgi_rd_pkg;

  // Record header length in bytes and the width of the byte position counter,
  // which must hold header + 65535 content + 255 padding bytes.
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned CntW     = 17;

  typedef enum logic [1:0] {
    RoleHeader  = 2'd0,
    RoleContent = 2'd1,
    RolePadding = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    RouteDiscard = 3'd0,
    RouteLocal   = 3'd1,
    RouteParams  = 3'd2,
    RouteStdin   = 3'd3,
    RouteData    = 3'd4
  } route_e;

  localparam logic [7:0] TypeBegin     = 8'd1;
  localparam logic [7:0] TypeAbort     = 8'd2;
  localparam logic [7:0] TypeParams    = 8'd4;
  localparam logic [7:0] TypeStdin     = 8'd5;
  localparam logic [7:0] TypeData      = 8'd8;
  localparam logic [7:0] TypeGetValues = 8'd9;

  localparam logic [15:0] BeginLen = 16'd8;
  localparam logic [15:0] AbortLen = 16'd0;
  localparam logic [15:0] MgmtId   = 16'd0;

  // Raw header fields as they arrive.
  typedef struct packed {
    logic [7:0]  rtype;
    logic [15:0] rid;
    logic [15:0] clen;
    logic [7:0]  plen;
  } hdr_t;

  // Header fields with the outcome of the local checks.
  typedef struct packed {
    hdr_t   f;
    logic   invalid;
    route_e route;
  } dec_t;

endpackage

@@ sv/fcgi_rd_hdr_dec.sv @@
// ----------------------------------------------------------------------------
// FastCGI record header decoder
// Applies the local header checks and chooses the content route of a record.
// ----------------------------------------------------------------------------
module fcgi_rd_hdr_dec (
  input  fcgi_rd_pkg::hdr_t hdr_i,
  output fcgi_rd_pkg::dec_t dec_o
);

  logic mgmt;
  logic invalid;

  assign mgmt = (hdr_i.rid == fcgi_rd_pkg::MgmtId);

  // Management records are never rejected.
  always_comb begin
    invalid = 1'b0;
    if (!mgmt) begin
      case (hdr_i.rtype)
        fcgi_rd_pkg::TypeBegin:  invalid = (hdr_i.clen != fcgi_rd_pkg::BeginLen);
        fcgi_rd_pkg::TypeAbort:  invalid = (hdr_i.clen != fcgi_rd_pkg::AbortLen);
        fcgi_rd_pkg::TypeParams: invalid = 1'b0;
        fcgi_rd_pkg::TypeStdin:  invalid = 1'b0;
        fcgi_rd_pkg::TypeData:   invalid = 1'b0;
        default:                 invalid = 1'b1;
      endcase
    end
  end

  always_comb begin
    dec_o.f       = hdr_i;
    dec_o.invalid = invalid;
    dec_o.route   = fcgi_rd_pkg::RouteDiscard;
    if (!invalid) begin
      if (mgmt) begin
        dec_o.route = fcgi_rd_pkg::RouteLocal;
      end else begin
        case (hdr_i.rtype)
          fcgi_rd_pkg::TypeBegin:  dec_o.route = fcgi_rd_pkg::RouteLocal;
          fcgi_rd_pkg::TypeAbort:  dec_o.route = fcgi_rd_pkg::RouteLocal;
          fcgi_rd_pkg::TypeParams: dec_o.route = fcgi_rd_pkg::RouteParams;
          fcgi_rd_pkg::TypeStdin:  dec_o.route = fcgi_rd_pkg::RouteStdin;
          fcgi_rd_pkg::TypeData:   dec_o.route = fcgi_rd_pkg::RouteData;
          default:                 dec_o.route = fcgi_rd_pkg::RouteDiscard;
        endcase
      end
    end
  end

endmodule

@@ sv/fastcgi_record_deframer.sv @@
// ----------------------------------------------------------------------------
// FastCGI record deframer
// Splits a connection byte stream into FastCGI records and tags every byte.
// ----------------------------------------------------------------------------
// The deframer takes one connection byte per request and returns one tagged
// result per byte, at a sustained rate of one byte per clock cycle while the
// consumer accepts results. A byte is held in an input register, where the
// record position counter and the held header decide its role, and its result
// is then captured in the output register. in_ready_o follows out_ready_i
// combinationally, so a stalled consumer stops the input within the same
// cycle. Header fields read as zero until the eighth header byte completes the
// header, and the position counter and held header return to zero after the
// byte that ends the record.
module fastcgi_record_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  byte_role_o,
  output logic [7:0]  content_byte_o,
  output logic [7:0]  record_type_o,
  output logic [15:0] record_id_o,
  output logic [15:0] content_length_o,
  output logic [7:0]  padding_length_o,
  output logic [2:0]  route_o,
  output logic        record_invalid_o,
  output logic        header_done_o,
  output logic        record_end_o,
  output logic        unknown_management_o
);

  localparam int unsigned CntW   = fcgi_rd_pkg::CntW;
  localparam int unsigned NumHdr = fcgi_rd_pkg::HdrBytes - 2;

  // Input stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       adv;

  // Record state.
  logic [CntW-1:0]    cnt_q, cnt_d, cnt_nxt;
  fcgi_rd_pkg::dec_t  held_q, held_d, held_nxt;
  logic [7:0]         hdr_q [NumHdr];
  fcgi_rd_pkg::hdr_t  hdr;
  fcgi_rd_pkg::dec_t  dec;

  // Result stage.
  logic                out_valid_q;
  fcgi_rd_pkg::role_e  role_d, role_q;
  logic [7:0]          cbyte_d, cbyte_q;
  fcgi_rd_pkg::route_e route_d, route_q;
  fcgi_rd_pkg::hdr_t   fld_q;
  logic                inv_q;
  logic                hdone_d, hdone_q;
  logic                rend_d, rend_q;
  logic                umgmt_d, umgmt_q;

  logic [CntW-1:0] content_end;
  logic [CntW-1:0] total;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
  end

  // Header bytes one to six; the version and reserved bytes are not kept.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumHdr; k++) begin
      if (adv && cnt_q == CntW'(k + 1)) begin
        hdr_q[k] <= in_byte_q;
      end
    end
  end

  assign hdr.rtype = hdr_q[0];
  assign hdr.rid   = {hdr_q[1], hdr_q[2]};
  assign hdr.clen  = {hdr_q[3], hdr_q[4]};
  assign hdr.plen  = hdr_q[5];

  fcgi_rd_hdr_dec u_hdr_dec (
    .hdr_i (hdr),
    .dec_o (dec)
  );

  assign content_end = CntW'(fcgi_rd_pkg::HdrBytes) + CntW'(held_q.f.clen);

  always_comb begin
    held_nxt = held_q;
    cnt_nxt  = cnt_q + CntW'(1);
    role_d   = fcgi_rd_pkg::RoleHeader;
    cbyte_d  = 8'd0;
    route_d  = fcgi_rd_pkg::RouteDiscard;
    hdone_d  = 1'b0;
    if (cnt_q < CntW'(fcgi_rd_pkg::HdrBytes)) begin
      if (cnt_q == CntW'(fcgi_rd_pkg::HdrBytes - 1)) begin
        held_nxt = dec;
        hdone_d  = 1'b1;
      end
    end else if (cnt_q < content_end) begin
      role_d  = fcgi_rd_pkg::RoleContent;
      cbyte_d = in_byte_q;
      route_d = held_q.route;
    end else begin
      role_d = fcgi_rd_pkg::RolePadding;
    end
  end

  // The end test uses the header just decoded, so an empty record ends on
  // its last header byte.
  assign total = CntW'(fcgi_rd_pkg::HdrBytes) + CntW'(held_nxt.f.clen)
                 + CntW'(held_nxt.f.plen);
  assign rend_d  = (cnt_nxt >= CntW'(fcgi_rd_pkg::HdrBytes)) && (cnt_nxt >= total);
  assign umgmt_d = (cnt_nxt >= CntW'(fcgi_rd_pkg::HdrBytes))
                   && (held_nxt.f.rid == fcgi_rd_pkg::MgmtId)
                   && (held_nxt.f.rtype != fcgi_rd_pkg::TypeGetValues);

  always_comb begin
    cnt_d  = cnt_q;
    held_d = held_q;
    if (adv) begin
      if (rend_d) begin
        cnt_d  = '0;
        held_d = '0;
      end else begin
        cnt_d  = cnt_nxt;
        held_d = held_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      held_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      role_q  <= role_d;
      cbyte_q <= cbyte_d;
      route_q <= route_d;
      fld_q   <= held_nxt.f;
      inv_q   <= held_nxt.invalid;
      hdone_q <= hdone_d;
      rend_q  <= rend_d;
      umgmt_q <= umgmt_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign byte_role_o          = role_q;
  assign content_byte_o       = cbyte_q;
  assign record_type_o        = fld_q.rtype;
  assign record_id_o          = fld_q.rid;
  assign content_length_o     = fld_q.clen;
  assign padding_length_o     = fld_q.plen;
  assign route_o              = route_q;
  assign record_invalid_o     = inv_q;
  assign header_done_o        = hdone_q;
  assign record_end_o         = rend_q;
  assign unknown_management_o = umgmt_q;

endmodule
